### hdl/scoohp_pkg.sv
package scoohp_pkg;

   // Field widths fixed by the item format
   localparam int COORD_W = 16;
   localparam int VALUE_W = 32;
   localparam int OINDEX_W = 12;
   localparam int PROD_W = 2 * VALUE_W;
   localparam int FRAC_W = 16;

   // Output index saturates here
   localparam logic [OINDEX_W-1:0] OINDEX_MAX = {OINDEX_W{1'b1}};

   // Saturation limits of a Q16.16 value
   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // Request opcodes
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_PROBE = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PRODUCT  = 2'd0,
      KIND_FULL     = 2'd1,
      KIND_MISMATCH = 2'd2
   } kind_type;

   // Register word indexes
   typedef enum logic [2:0] {
      REG_FIRST_ROWS  = 3'd0,
      REG_FIRST_COLS  = 3'd1,
      REG_SECOND_ROWS = 3'd2,
      REG_SECOND_COLS = 3'd3,
      REG_RESULT_ROWS = 3'd4,
      REG_RESULT_COLS = 3'd5
   } reg_index_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SCAN,
      ST_MULT,
      ST_EMIT,
      ST_ERR_FULL,
      ST_ERR_DIM
   } state_type;

   // Configured dimensions
   typedef struct packed {
      logic [COORD_W-1:0] first_rows;
      logic [COORD_W-1:0] first_cols;
      logic [COORD_W-1:0] second_rows;
      logic [COORD_W-1:0] second_cols;
      logic [COORD_W-1:0] result_rows;
      logic [COORD_W-1:0] result_cols;
   } dims_type;

   // Controller to datapath
   typedef struct packed {
      logic     store;
      logic     clear;
      logic     capture;
      logic     compare;
      logic     read;
      logic     mult;
      logic     emit_prod;
      logic     emit_err;
      kind_type err_kind;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;
      logic mismatch;
      logic match_any;
      logic last;
      logic out_free;
   } status_type;

endpackage

### hdl/scoohp_csr.sv
module scoohp_csr
   import scoohp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output dims_type    dims
);

   dims_type      dims_ff;
   dims_type      dims_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[4:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign dims    = dims_ff;

   // Register write decode
   always_comb begin
      dims_in = dims_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_FIRST_ROWS:  dims_in.first_rows  = pwdata[COORD_W-1:0];
            REG_FIRST_COLS:  dims_in.first_cols  = pwdata[COORD_W-1:0];
            REG_SECOND_ROWS: dims_in.second_rows = pwdata[COORD_W-1:0];
            REG_SECOND_COLS: dims_in.second_cols = pwdata[COORD_W-1:0];
            REG_RESULT_ROWS: dims_in.result_rows = pwdata[COORD_W-1:0];
            REG_RESULT_COLS: dims_in.result_cols = pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '0;
      end else begin
         dims_ff <= dims_in;
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         REG_FIRST_ROWS:  prdata[COORD_W-1:0] = dims_ff.first_rows;
         REG_FIRST_COLS:  prdata[COORD_W-1:0] = dims_ff.first_cols;
         REG_SECOND_ROWS: prdata[COORD_W-1:0] = dims_ff.second_rows;
         REG_SECOND_COLS: prdata[COORD_W-1:0] = dims_ff.second_cols;
         REG_RESULT_ROWS: prdata[COORD_W-1:0] = dims_ff.result_rows;
         REG_RESULT_COLS: prdata[COORD_W-1:0] = dims_ff.result_cols;
         default: prdata = '0;
      endcase
   end

endmodule

### hdl/scoohp_ctrl.sv
module scoohp_ctrl
   import scoohp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff;
   state_type  state_in;
   opcode_type opcode;

   assign opcode = opcode_type'(req_opcode);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.err_kind = KIND_FULL;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (opcode)
                  OP_LOAD: begin
                     if (status.full) begin
                        state_in = ST_ERR_FULL;
                     end else begin
                        cmd.store = 1'b1;
                     end
                  end
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_PROBE: begin
                     cmd.capture = 1'b1;
                     state_in = status.mismatch ? ST_ERR_DIM : ST_COMPARE;
                  end
                  default: ;
               endcase
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.match_any) begin
               cmd.read = 1'b1;
               state_in = ST_MULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_prod = 1'b1;
               state_in = status.last ? ST_IDLE : ST_SCAN;
            end
         end
         ST_ERR_FULL: begin
            cmd.err_kind = KIND_FULL;
            if (status.out_free) begin
               cmd.emit_err = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ERR_DIM: begin
            cmd.err_kind = KIND_MISMATCH;
            if (status.out_free) begin
               cmd.emit_err = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### hdl/scoohp_dp.sv
module scoohp_dp
   import scoohp_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  dims_type                   dims,
   input  logic [COORD_W-1:0]         req_row_index,
   input  logic [COORD_W-1:0]         req_col_index,
   input  logic signed [VALUE_W-1:0]  req_entry_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [COORD_W-1:0]         rsp_out_row,
   output logic [COORD_W-1:0]         rsp_out_col,
   output logic signed [VALUE_W-1:0]  rsp_product,
   output logic [OINDEX_W-1:0]        rsp_out_index,
   output logic                       rsp_last
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Table: coordinates in per-slot registers for the parallel compare,
   // values in a memory read one slot at a time
   logic [COORD_W-1:0] slot_row_ff [TABLE_DEPTH];
   logic [COORD_W-1:0] slot_col_ff [TABLE_DEPTH];
   logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];

   logic [CNT_W-1:0]    entry_count_ff;
   logic [OINDEX_W-1:0] product_count_ff;
   logic [IDX_W-1:0]    wr_idx;

   // Captured probe
   logic [COORD_W-1:0]        row_ff;
   logic [COORD_W-1:0]        col_ff;
   logic signed [VALUE_W-1:0] val_ff;

   // Match scan
   logic [TABLE_DEPTH-1:0]    match_ff;
   logic [TABLE_DEPTH-1:0]    match_in;
   logic [TABLE_DEPTH-1:0]    match_rest;
   logic [IDX_W-1:0]          pick_idx;
   logic                      last_ff;
   logic signed [VALUE_W-1:0] rd_value_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [VALUE_W-1:0]        sat_value;

   // Output register
   logic                      rsp_valid_ff;
   kind_type                  kind_ff;
   logic [COORD_W-1:0]        out_row_ff;
   logic [COORD_W-1:0]        out_col_ff;
   logic [VALUE_W-1:0]        product_ff;
   logic [OINDEX_W-1:0]       out_index_ff;
   logic                      out_last_ff;
   logic                      out_free;

   assign wr_idx   = entry_count_ff[IDX_W-1:0];
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Status back to the controller
   assign status.full      = (entry_count_ff == CNT_W'(TABLE_DEPTH));
   assign status.mismatch  = (dims.first_rows != dims.second_rows) ||
                             (dims.first_cols != dims.second_cols) ||
                             (dims.first_rows != dims.result_rows) ||
                             (dims.first_cols != dims.result_cols);
   assign status.match_any = |match_ff;
   assign status.last      = last_ff;
   assign status.out_free  = out_free;

   // Table writes and value memory read
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_row_ff[wr_idx] <= req_row_index;
         slot_col_ff[wr_idx] <= req_col_index;
         value_mem[wr_idx]   <= req_entry_value;
      end
      if (cmd.read) begin
         rd_value_ff <= value_mem[pick_idx];
      end
   end

   // Fill count and product index
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= '0;
         product_count_ff <= '0;
      end else begin
         if (cmd.clear) begin
            entry_count_ff   <= '0;
            product_count_ff <= '0;
         end else begin
            if (cmd.store) begin
               entry_count_ff <= entry_count_ff + CNT_W'(1);
            end
            if (cmd.emit_prod && product_count_ff != OINDEX_MAX) begin
               product_count_ff <= product_count_ff + OINDEX_W'(1);
            end
         end
      end
   end

   // Probe capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
         val_ff <= req_entry_value;
      end
   end

   // Lowest pending match goes first
   always_comb begin
      pick_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            pick_idx = IDX_W'(i);
         end
      end
      match_rest = match_ff;
      match_rest[pick_idx] = 1'b0;
   end

   // Parallel compare against every filled slot
   always_comb begin
      match_in = match_ff;
      if (cmd.compare) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            match_in[i] = (CNT_W'(i) < entry_count_ff) &&
                          (slot_row_ff[i] == row_ff) &&
                          (slot_col_ff[i] == col_ff);
         end
      end else if (cmd.read) begin
         match_in = match_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         last_ff <= ~|match_rest;
      end
   end

   // Full-width product, registered before saturation
   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= val_ff * rd_value_ff;
      end
   end

   // Drop 16 fraction bits, clamp when bits above the kept word disagree
   always_comb begin
      if (!prod_ff[PROD_W-1] && |prod_ff[PROD_W-2:VALUE_W+FRAC_W-1]) begin
         sat_value = VALUE_MAX;
      end else if (prod_ff[PROD_W-1] && !(&prod_ff[PROD_W-2:VALUE_W+FRAC_W-1])) begin
         sat_value = VALUE_MIN;
      end else begin
         sat_value = prod_ff[VALUE_W+FRAC_W-1:FRAC_W];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_prod || cmd.emit_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_prod) begin
         kind_ff      <= KIND_PRODUCT;
         out_row_ff   <= row_ff;
         out_col_ff   <= col_ff;
         product_ff   <= sat_value;
         out_index_ff <= product_count_ff;
         out_last_ff  <= last_ff;
      end else if (cmd.emit_err) begin
         kind_ff      <= cmd.err_kind;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         product_ff   <= '0;
         out_index_ff <= '0;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_product   = product_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_last      = out_last_ff;

endmodule

### hdl/sparse_coo_hadamard_product.sv
// Element-wise product of two sparse coordinate-list matrices. Load
// transactions fill a table of up to TABLE_DEPTH entries of the second
// matrix; each probe transaction brings one entry of the first matrix, is
// compared against all filled slots at once, and returns one Q16.16 product
// per matching slot in slot order (floored, saturated, numbered by a
// saturating running index), the final one flagged last. A probe while the
// three row or the three column dimension registers disagree returns a
// single mismatch result, and a load into a full table a single table-full
// result. A probe is accepted, compared in parallel, then scanned; each
// match then takes a value memory read, a multiply, and a saturate into the
// output register, one match at a time through the single shared multiplier
// and the one-read value memory. An error result is emitted from its own
// state after the accept. A new request is taken only once the last one is
// done, and emitting waits while the output register holds an unaccepted
// result. No clearing pass is needed after reset.
module sparse_coo_hadamard_product
   import scoohp_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic [15:0]                req_row_index,
   input  logic [15:0]                req_col_index,
   input  logic signed [31:0]         req_entry_value,
   // Response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [15:0]                rsp_out_row,
   output logic [15:0]                rsp_out_col,
   output logic signed [31:0]         rsp_product,
   output logic [11:0]                rsp_out_index,
   output logic                       rsp_last,
   // Register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [4:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   dims_type   dims;
   cmd_type    cmd;
   status_type status;

   scoohp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .dims    (dims)
   );

   scoohp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   scoohp_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .dims            (dims),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_product     (rsp_product),
      .rsp_out_index   (rsp_out_index),
      .rsp_last        (rsp_last)
   );

endmodule
